FILE: design/tarcp_pkg.sv
// Package for the time and rate command parser: beat types, parser state,
// prefix tables and small decode helpers. No dependencies.
`default_nettype none

package tarcp_pkg;

    // Prefix tracking while the command text comes in
    typedef enum logic [1:0] {
        PS_UNDECIDED = 2'd0,
        PS_TIME      = 2'd1,
        PS_RATE      = 2'd2,
        PS_NONE      = 2'd3
    } t_prefix_state;

    // Command kind reported with each verdict
    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_TIME    = 2'd1,
        KIND_RATE    = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_command;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] command_kind;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [5:0] rate_seconds;
    } t_out_beat;

    typedef struct packed {
        logic [4:0]    chars_seen;
        t_prefix_state prefix_state;
        logic          format_good;
        logic          string_ended;
        logic [6:0]    hour_acc;
        logic [6:0]    minute_acc;
        logic [6:0]    second_acc;
        logic [6:0]    rate_acc;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        chars_seen:   5'd0,
        prefix_state: PS_UNDECIDED,
        format_good:  1'b1,
        string_ended: 1'b0,
        hour_acc:     7'd0,
        minute_acc:   7'd0,
        second_acc:   7'd0,
        rate_acc:     7'd0
    };

    localparam logic [4:0] CHARS_MAX       = 5'd31;
    localparam logic [4:0] COMMON_LEN      = 5'd5;
    localparam logic [4:0] TIME_PREFIX_LEN = 5'd9;
    localparam logic [4:0] RATE_PREFIX_LEN = 5'd7;
    localparam logic [4:0] TIME_TOTAL_LEN  = 5'd17;
    localparam logic [4:0] RATE_LEN_SHORT  = 5'd8;
    localparam logic [4:0] RATE_LEN_LONG   = 5'd9;

    localparam logic [6:0] HOURS_MAX   = 7'd23;
    localparam logic [6:0] MINUTES_MAX = 7'd59;
    localparam logic [6:0] SECONDS_MAX = 7'd59;
    localparam logic [6:0] RATE_MIN    = 7'd2;
    localparam logic [6:0] RATE_MAX    = 7'd60;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_M     = 8'h4D;

    // Expected character of the clock command prefix at a position below nine
    function automatic logic [7:0] time_prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h53; // S
            4'd1:    ch = 8'h45; // E
            4'd2:    ch = 8'h54; // T
            4'd3:    ch = 8'h5F; // _
            4'd4:    ch = 8'h54; // T
            4'd5:    ch = 8'h49; // I
            4'd6:    ch = 8'h4D; // M
            4'd7:    ch = 8'h45; // E
            4'd8:    ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected character of "SET_TM=" at a position below seven
    function automatic logic [7:0] rate_prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h53; // S
            3'd1:    ch = 8'h45; // E
            3'd2:    ch = 8'h54; // T
            3'd3:    ch = 8'h5F; // _
            3'd4:    ch = 8'h54; // T
            3'd5:    ch = 8'h4D; // M
            3'd6:    ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    endfunction

    // acc * 10 + digit, kept to seven bits
    function automatic logic [6:0] mac10(input logic [6:0] acc, input logic [7:0] ch);
        logic [9:0] sum;
        logic [7:0] dig;
        dig = ch - CHAR_ZERO;
        sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'd0, dig[3:0]};
        return sum[6:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/tarcp_step.sv
// Per-character state update and end-of-command verdict for the parser.
// Pure combinational; depends on tarcp_pkg.
`default_nettype none

module tarcp_step
    import tarcp_pkg::*;
(
    input  wire t_parse_state i_state,
    input  wire logic [7:0]   i_char_code,
    output t_parse_state      o_next_state,
    output t_out_beat         o_verdict
);

    logic [4:0] w_pos;
    logic [7:0] w_char;

    assign w_pos  = i_state.chars_seen;
    assign w_char = i_char_code;

    // Advance the parse state by one character
    always_comb begin
        o_next_state = i_state;
        if (!i_state.string_ended) begin
            if (w_char == CHAR_NUL) begin
                o_next_state.string_ended = 1'b1;
            end else begin
                unique case (i_state.prefix_state)
                    PS_UNDECIDED: begin
                        if (w_pos < COMMON_LEN) begin
                            if (w_char != time_prefix_char(w_pos[3:0]))
                                o_next_state.prefix_state = PS_NONE;
                        end else if (w_char == CHAR_I) begin
                            o_next_state.prefix_state = PS_TIME;
                        end else if (w_char == CHAR_M) begin
                            o_next_state.prefix_state = PS_RATE;
                        end else begin
                            o_next_state.prefix_state = PS_NONE;
                        end
                    end
                    PS_TIME: begin
                        if (w_pos < TIME_PREFIX_LEN) begin
                            if (w_char != time_prefix_char(w_pos[3:0]))
                                o_next_state.prefix_state = PS_NONE;
                        end else begin
                            case (w_pos) inside
                                5'd9, 5'd10: begin
                                    if (is_digit(w_char))
                                        o_next_state.hour_acc = mac10(i_state.hour_acc, w_char);
                                    else
                                        o_next_state.format_good = 1'b0;
                                end
                                5'd12, 5'd13: begin
                                    if (is_digit(w_char))
                                        o_next_state.minute_acc =
                                            mac10(i_state.minute_acc, w_char);
                                    else
                                        o_next_state.format_good = 1'b0;
                                end
                                5'd15, 5'd16: begin
                                    if (is_digit(w_char))
                                        o_next_state.second_acc =
                                            mac10(i_state.second_acc, w_char);
                                    else
                                        o_next_state.format_good = 1'b0;
                                end
                                5'd11, 5'd14: begin
                                    if (w_char != CHAR_COLON)
                                        o_next_state.format_good = 1'b0;
                                end
                                default: o_next_state.format_good = 1'b0;
                            endcase
                        end
                    end
                    PS_RATE: begin
                        if (w_pos < RATE_PREFIX_LEN) begin
                            if (w_char != rate_prefix_char(w_pos[2:0]))
                                o_next_state.prefix_state = PS_NONE;
                        end else if (w_pos == RATE_LEN_SHORT - 5'd1
                                     || w_pos == RATE_LEN_LONG - 5'd1) begin
                            if (is_digit(w_char))
                                o_next_state.rate_acc = mac10(i_state.rate_acc, w_char);
                            else
                                o_next_state.format_good = 1'b0;
                        end else begin
                            o_next_state.format_good = 1'b0;
                        end
                    end
                    PS_NONE: ;
                    default: ;
                endcase
                // Saturate the position count
                if (i_state.chars_seen != CHARS_MAX)
                    o_next_state.chars_seen = i_state.chars_seen + 5'd1;
            end
        end
    end

    // Judge the command seen so far
    always_comb begin
        o_verdict = '0;
        o_verdict.command_kind = KIND_INVALID;
        if (i_state.prefix_state == PS_TIME && i_state.format_good
            && i_state.chars_seen == TIME_TOTAL_LEN
            && i_state.hour_acc <= HOURS_MAX && i_state.minute_acc <= MINUTES_MAX
            && i_state.second_acc <= SECONDS_MAX) begin
            o_verdict.command_kind = KIND_TIME;
            o_verdict.hours        = i_state.hour_acc[4:0];
            o_verdict.minutes      = i_state.minute_acc[5:0];
            o_verdict.seconds      = i_state.second_acc[5:0];
        end else if (i_state.prefix_state == PS_RATE && i_state.format_good
                     && (i_state.chars_seen == RATE_LEN_SHORT
                         || i_state.chars_seen == RATE_LEN_LONG)
                     && i_state.rate_acc >= RATE_MIN && i_state.rate_acc <= RATE_MAX) begin
            o_verdict.command_kind = KIND_RATE;
            o_verdict.rate_seconds = i_state.rate_acc[5:0];
        end
    end

endmodule

`default_nettype wire

FILE: design/time_and_rate_command_parser.sv
// Top level of the terminal command parser: parse state register, output register.
// Depends on tarcp_pkg and tarcp_step.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_beat) carries one command
//   character per beat, then one beat with end_of_command set. Character beats
//   produce no result; the end beat produces exactly one result beat on the
//   output channel (o_out_valid / i_out_ready / o_out_beat) carrying the command
//   kind and the decoded hours, minutes, seconds or sampling interval.
//   Throughput: one input beat per cycle while o_in_ready is high. Each character
//   updates the parse state register in the cycle it is accepted; the verdict is
//   loaded into the output register on the end beat, visible in the next cycle.
//   The parse state returns to its reset value after each end beat, so the next
//   command may follow in the very next cycle.
//   Stall: while a result waits in the output register and the receiver holds
//   i_out_ready low, o_in_ready drops; it rises again in the cycle the result
//   is taken, so back-to-back commands see no stall while the receiver keeps up.
//   Reset (i_rst_n low, synchronous): clears the parse state and empties the
//   output register.
`default_nettype none

module time_and_rate_command_parser
    import tarcp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_out_beat    r_out_beat;
    t_out_beat    n_out_beat;
    logic         r_out_valid;
    logic         w_in_accept;
    logic         w_end_accept;

    // Per-character update and verdict
    tarcp_step u_step (
        .i_state      (r_state),
        .i_char_code  (i_in_beat.char_code),
        .o_next_state (n_state),
        .o_verdict    (n_out_beat)
    );

    // Accept while the output register is empty or being drained
    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign w_in_accept  = i_in_valid && o_in_ready;
    assign w_end_accept = w_in_accept && i_in_beat.end_of_command;

    // Hold or advance the parse state; clear it after each end beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_in_accept) begin
            if (i_in_beat.end_of_command)
                r_state <= STATE_RESET;
            else
                r_state <= n_state;
        end
    end

    // Output register: load on end beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_end_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end_accept)
            r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTH
    // A result appears only after an end beat
    a_out_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_end_accept))
        else $error("result beat without end marker");

    // Parse state is back at reset after an end beat
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_accept |=> (r_state == STATE_RESET))
        else $error("parse state not cleared after end marker");

    // Invalid verdicts carry zero values
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.command_kind == KIND_INVALID) |->
            (r_out_beat.hours == 5'd0 && r_out_beat.minutes == 6'd0
             && r_out_beat.seconds == 6'd0 && r_out_beat.rate_seconds == 6'd0))
        else $error("invalid verdict with nonzero values");

    // Time verdicts stay in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.command_kind == KIND_TIME) |->
            (r_out_beat.hours <= 5'd23 && r_out_beat.minutes <= 6'd59
             && r_out_beat.seconds <= 6'd59 && r_out_beat.rate_seconds == 6'd0))
        else $error("time verdict out of range");

    // Position count never moves while the string has ended, but for the reset on an end beat
    a_ended_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.string_ended && !w_end_accept) |=> $stable(r_state.chars_seen))
        else $error("position advanced after zero character");
`endif

endmodule

`default_nettype wire
